// ===== hw/rtl/trfd_pkg.sv =====
`default_nettype none

package trfd_pkg;

    // Point capacity of the job format; HW_POINTS may be 1 up to this
    localparam int POINT_SLOTS       = 2;
    localparam int HW_POINTS_DEFAULT = 2;

    // Frame-to-result queue depth
    localparam int QUEUE_DEPTH = 2;

    // Widths
    localparam int COORD_W   = 12;
    localparam int CNT_W     = $clog2(POINT_SLOTS + 1);
    localparam int IDX_W     = $clog2(POINT_SLOTS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Frame layout and byte codes
    localparam logic [7:0] ACK_CODE    = 8'hAB;
    localparam logic [7:0] HDR_EMPTY   = 8'h00;
    localparam logic [6:0] COUNT_MASK  = 7'h7F;
    localparam int         LID_BIT     = 7;
    localparam int         BYTE_LID    = 4;
    localparam int         BYTE_COUNT  = 5;
    localparam int         BYTE_ACK    = 6;
    localparam logic [3:0] EV_IDLE     = 4'h0;
    localparam logic [3:0] EV_SKIP     = 4'h5;

    // Frame classification
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DROP  = 2'd1,
        ST_VALID = 2'd2
    } status_t;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_X_MAX    = 3'd0,
        REG_AXIS_Y_MAX    = 3'd1,
        REG_MIRROR_X_EN   = 3'd2,
        REG_MIRROR_Y_EN   = 3'd3,
        REG_SWAP_AXES_EN  = 3'd4,
        REG_POINTS_WANTED = 3'd5
    } cfg_reg_t;

    localparam logic [1:0] POINTS_WANTED_RESET = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] axis_x_max;
        logic [COORD_W-1:0] axis_y_max;
        logic               mirror_x_en;
        logic               mirror_y_en;
        logic               swap_axes_en;
        logic [1:0]         points_wanted;
    } cfg_t;

    // One decoded frame, kept points packed to the low slots
    typedef struct packed {
        status_t                             status;
        logic [CNT_W-1:0]                    kept;
        logic [POINT_SLOTS-1:0][COORD_W-1:0] px;
        logic [POINT_SLOTS-1:0][COORD_W-1:0] py;
    } job_t;

    // One result beat
    typedef struct packed {
        status_t            frame_status;
        logic               ack_needed;
        logic               point_valid;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [CNT_W-1:0]   point_total;
        logic               last_of_frame;
    } beat_t;

    // Byte offset of point i within the frame
    function automatic int point_offset(input int i);
        return i * 5 + ((i == 0) ? 0 : 2);
    endfunction

    // Frame length for a given point capacity
    function automatic int frame_len(input int points);
        return points * 5 + 5;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/touch_report_frame_decoder.sv =====
// Touch report frame decoder. Report bytes enter on the in_valid/in_ready
// channel at one beat per cycle; a frame is HW_POINTS*5+5 bytes. When the final
// byte is taken, the front end judges the whole frame in that cycle (idle, dropped
// or valid, with kept points packed) and pushes one job into a two-entry queue.
// The back end turns each job into one result beat (idle, dropped, or valid with
// no kept point) or one beat per kept point, one beat per cycle while out_ready is
// high, through a registered output stage that applies mirror and swap; the input
// stalls only on a frame's final byte while the queue holds two pending frames.
// Configuration writes are always taken and must happen while the block is idle.
`default_nettype none

module touch_report_frame_decoder #(
    parameter int HW_POINTS = trfd_pkg::HW_POINTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [trfd_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     report_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          frame_status,
    output logic                                ack_needed,
    output logic                                point_valid,
    output logic [11:0]                         point_x,
    output logic [11:0]                         point_y,
    output logic [1:0]                          point_total,
    output logic                                last_of_frame
);

    trfd_pkg::cfg_t  cfg;
    trfd_pkg::job_t  push_job;
    trfd_pkg::job_t  head;
    trfd_pkg::beat_t beat;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_empty;

    // Configuration registers
    trfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Byte collection and frame classification
    trfd_front #(
        .HW_POINTS (HW_POINTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .report_byte   (report_byte),
        .points_wanted (cfg.points_wanted),
        .queue_full    (queue_full),
        .push          (push),
        .push_job      (push_job)
    );

    // Decoded frame queue
    trfd_job_fifo #(
        .DEPTH (trfd_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    // Result beat generation
    trfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .beat      (beat)
    );

    assign frame_status  = beat.frame_status;
    assign ack_needed    = beat.ack_needed;
    assign point_valid   = beat.point_valid;
    assign point_x       = beat.point_x;
    assign point_y       = beat.point_y;
    assign point_total   = beat.point_total;
    assign last_of_frame = beat.last_of_frame;

endmodule

`default_nettype wire

// ===== hw/rtl/trfd_cfg_regs.sv =====
`default_nettype none

module trfd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [trfd_pkg::CFG_DAT_W-1:0] cfg_data,
    output trfd_pkg::cfg_t                      cfg
);

    trfd_pkg::cfg_t cfg_reg;
    trfd_pkg::cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (trfd_pkg::cfg_reg_t'(cfg_index))
                trfd_pkg::REG_AXIS_X_MAX:    cfg_next.axis_x_max    = cfg_data;
                trfd_pkg::REG_AXIS_Y_MAX:    cfg_next.axis_y_max    = cfg_data;
                trfd_pkg::REG_MIRROR_X_EN:   cfg_next.mirror_x_en   = cfg_data[0];
                trfd_pkg::REG_MIRROR_Y_EN:   cfg_next.mirror_y_en   = cfg_data[0];
                trfd_pkg::REG_SWAP_AXES_EN:  cfg_next.swap_axes_en  = cfg_data[0];
                trfd_pkg::REG_POINTS_WANTED: cfg_next.points_wanted = cfg_data[1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{axis_x_max:    '0,
                         axis_y_max:    '0,
                         mirror_x_en:   1'b0,
                         mirror_y_en:   1'b0,
                         swap_axes_en:  1'b0,
                         points_wanted: trfd_pkg::POINTS_WANTED_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trfd_front.sv =====
`default_nettype none

module trfd_front #(
    parameter int HW_POINTS = trfd_pkg::HW_POINTS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] report_byte,
    input  wire logic [1:0] points_wanted,
    input  wire logic       queue_full,
    output logic            push,
    output trfd_pkg::job_t  push_job
);

    localparam int FrameLen = trfd_pkg::frame_len(HW_POINTS);
    localparam int PosW     = $clog2(FrameLen);
    localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

    logic [PosW-1:0]              byte_position_reg;
    logic [PosW-1:0]              byte_position_next;
    logic                         any_nonzero_reg;
    logic                         any_nonzero_next;
    logic [FrameLen-1:0][7:0]     frame_store_reg;
    logic [FrameLen-1:0][7:0]     view;
    logic                         at_last;
    logic                         accept;
    logic                         nonzero;
    logic                         drop;
    logic [6:0]                   num;
    logic [trfd_pkg::CNT_W-1:0]   want;
    logic [trfd_pkg::CNT_W-1:0]   cnt;
    logic [3:0]                   ev;
    logic [PosW-1:0]              off;

    assign at_last  = (byte_position_reg == LastPos);
    assign in_ready = !at_last || !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && at_last;

    // Frame as seen with the incoming final byte in place
    always_comb
    begin
        for (int k = 0; k < FrameLen; k++)
        begin
            view[k] = (k == FrameLen - 1) ? report_byte : frame_store_reg[k];
        end
    end

    assign nonzero = any_nonzero_reg || (report_byte != 8'h00);
    assign drop    = (view[0] == trfd_pkg::ACK_CODE)
                  || (view[trfd_pkg::BYTE_ACK] != trfd_pkg::ACK_CODE)
                  || (view[0] == trfd_pkg::HDR_EMPTY)
                  || view[trfd_pkg::BYTE_LID][trfd_pkg::LID_BIT];
    assign num     = view[trfd_pkg::BYTE_COUNT][6:0] & trfd_pkg::COUNT_MASK;
    assign want    = (points_wanted == 2'd0) ? trfd_pkg::CNT_W'(1)
                                             : trfd_pkg::CNT_W'(points_wanted);

    // Classify the frame and pack kept points into the job
    always_comb
    begin
        push_job = '0;
        cnt      = '0;
        ev       = '0;
        off      = '0;
        priority if (!nonzero)
        begin
            push_job.status = trfd_pkg::ST_IDLE;
        end
        else if (drop)
        begin
            push_job.status = trfd_pkg::ST_DROP;
        end
        else
        begin
            push_job.status = trfd_pkg::ST_VALID;
            for (int i = 0; i < HW_POINTS; i++)
            begin
                off = PosW'(trfd_pkg::point_offset(i));
                ev  = view[off][3:0];
                if ((7'(i) < num) && (ev != trfd_pkg::EV_IDLE)
                    && (ev != trfd_pkg::EV_SKIP) && (cnt < want))
                begin
                    push_job.px[cnt[trfd_pkg::IDX_W-1:0]] =
                        {view[off + PosW'(1)], view[off + PosW'(3)][7:4]};
                    push_job.py[cnt[trfd_pkg::IDX_W-1:0]] =
                        {view[off + PosW'(2)], view[off + PosW'(3)][3:0]};
                    cnt = cnt + trfd_pkg::CNT_W'(1);
                end
            end
            push_job.kept = cnt;
        end
    end

    // Byte counter and nonzero tracking
    always_comb
    begin
        byte_position_next = byte_position_reg;
        any_nonzero_next   = any_nonzero_reg;
        if (accept)
        begin
            if (at_last)
            begin
                byte_position_next = '0;
                any_nonzero_next   = 1'b0;
            end
            else
            begin
                byte_position_next = byte_position_reg + PosW'(1);
                any_nonzero_next   = nonzero;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            any_nonzero_reg   <= 1'b0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            any_nonzero_reg   <= any_nonzero_next;
        end
    end

    // Frame store, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_store_reg[byte_position_reg] <= report_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trfd_job_fifo.sv =====
`default_nettype none

module trfd_job_fifo #(
    parameter int DEPTH = trfd_pkg::QUEUE_DEPTH
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  trfd_pkg::job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output trfd_pkg::job_t head,
    output logic           empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    trfd_pkg::job_t  slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Queue must never overrun or underrun
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("job queue pushed while full");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ===== hw/rtl/trfd_back.sv =====
`default_nettype none

module trfd_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  trfd_pkg::cfg_t cfg,
    input  trfd_pkg::job_t head,
    input  wire logic      empty,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output trfd_pkg::beat_t beat
);

    localparam int CW = trfd_pkg::COORD_W;

    logic [trfd_pkg::IDX_W-1:0] idx_reg;
    logic [trfd_pkg::IDX_W-1:0] idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    trfd_pkg::beat_t            beat_reg;
    trfd_pkg::beat_t            beat_next;
    logic                       load;
    logic [CW-1:0]              raw_x;
    logic [CW-1:0]              raw_y;
    logic [CW-1:0]              mir_x;
    logic [CW-1:0]              mir_y;

    assign out_valid = out_valid_reg;
    assign beat      = beat_reg;

    // Output register takes a new beat when empty or being drained
    assign load = !empty && (!out_valid_reg || out_ready);

    // Saturating mirror, then optional swap
    assign raw_x = head.px[idx_reg];
    assign raw_y = head.py[idx_reg];

    always_comb
    begin
        mir_x = raw_x;
        mir_y = raw_y;
        if (cfg.mirror_x_en && (cfg.axis_x_max != '0))
        begin
            mir_x = (raw_x < cfg.axis_x_max) ? (cfg.axis_x_max - raw_x) : '0;
        end
        if (cfg.mirror_y_en && (cfg.axis_y_max != '0))
        begin
            mir_y = (raw_y < cfg.axis_y_max) ? (cfg.axis_y_max - raw_y) : '0;
        end
    end

    // Build the beat for the current slot of the head job
    always_comb
    begin
        beat_next              = '0;
        beat_next.frame_status = head.status;
        beat_next.ack_needed   = (head.status != trfd_pkg::ST_IDLE);
        if (head.kept == '0)
        begin
            beat_next.last_of_frame = 1'b1;
        end
        else
        begin
            beat_next.point_valid   = 1'b1;
            beat_next.point_x       = cfg.swap_axes_en ? mir_y : mir_x;
            beat_next.point_y       = cfg.swap_axes_en ? mir_x : mir_y;
            beat_next.point_total   = head.kept;
            beat_next.last_of_frame =
                ((trfd_pkg::CNT_W'(idx_reg) + trfd_pkg::CNT_W'(1)) == head.kept);
        end
    end

    assign pop = load && beat_next.last_of_frame;

    // Slot index and valid flag
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = beat_next.last_of_frame ? '0
                                                     : idx_reg + trfd_pkg::IDX_W'(1);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat_next;
        end
    end

    // A point only comes from a valid frame with a nonzero total
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && beat_reg.point_valid) |->
            (beat_reg.frame_status == trfd_pkg::ST_VALID && beat_reg.point_total != '0))
        else $error("point beat outside a valid frame");
    // A pointless beat always closes its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !beat_reg.point_valid) |-> beat_reg.last_of_frame)
        else $error("pointless beat not marked last");

endmodule

`default_nettype wire

// ===== tb/tb_touch_report_frame_decoder.sv =====
`timescale 1ns / 1ps

module tb_touch_report_frame_decoder;
    import trfd_pkg::*;

    localparam int NPTS           = HW_POINTS_DEFAULT;
    localparam int FRAME_BYTES    = NPTS * 5 + 5;
    localparam int RANDOM_BYTES   = 1320;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef enum {
        FK_VALID,
        FK_IDLE,
        FK_NOISE,
        FK_HDR_ZERO,
        FK_HDR_ACK,
        FK_BAD_ACK,
        FK_LID
    } frame_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           report_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           frame_status;
    logic                 ack_needed;
    logic                 point_valid;
    logic [11:0]          point_x;
    logic [11:0]          point_y;
    logic [1:0]           point_total;
    logic                 last_of_frame;

    // Decoder state mirrored on the bench side
    frame_t      frame_bytes = '0;
    int          fill_pos = 0;
    bit          saw_nonzero = 1'b0;
    cfg_t        live_cfg = '{axis_x_max: '0, axis_y_max: '0, mirror_x_en: 1'b0,
                              mirror_y_en: 1'b0, swap_axes_en: 1'b0,
                              points_wanted: POINTS_WANTED_RESET};
    beat_t       decoded_beats[$];

    int          fail_count = 0;
    int          stall_cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    touch_report_frame_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .report_byte  (report_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .ack_needed   (ack_needed),
        .point_valid  (point_valid),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_total  (point_total),
        .last_of_frame(last_of_frame)
    );

    // Saturating reflection against the axis maximum
    function automatic logic [11:0] mirror_coord(input logic [11:0] v, input logic [11:0] m);
        return (v < m) ? (m - v) : 12'd0;
    endfunction

    // Judge the stored frame and queue the beats it should produce
    task automatic decode_stored_frame();
        logic [11:0] xs [NPTS];
        logic [11:0] ys [NPTS];
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] tmp;
        int          avail;
        int          cap;
        int          kept;
        int          i;
        int          base;
        beat_t       bt;
        bt = '0;
        bt.last_of_frame = 1'b1;
        if (!saw_nonzero)
        begin
            bt.frame_status = ST_IDLE;
            decoded_beats.push_back(bt);
            return;
        end
        bt.ack_needed = 1'b1;
        if (frame_bytes[0] == ACK_CODE || frame_bytes[0] == HDR_EMPTY
            || frame_bytes[BYTE_ACK] != ACK_CODE || frame_bytes[BYTE_LID][LID_BIT])
        begin
            bt.frame_status = ST_DROP;
            decoded_beats.push_back(bt);
            return;
        end
        avail = int'(frame_bytes[BYTE_COUNT] & {1'b0, COUNT_MASK});
        if (avail > NPTS)
            avail = NPTS;
        cap = (live_cfg.points_wanted == 2'd0) ? 1 : int'(live_cfg.points_wanted);
        kept = 0;
        for (i = 0; i < avail && kept < cap; i++)
        begin
            base = i * 5 + ((i == 0) ? 0 : 2);
            if (frame_bytes[base][3:0] == EV_IDLE || frame_bytes[base][3:0] == EV_SKIP)
                continue;
            cx = {frame_bytes[base + 1], frame_bytes[base + 3][7:4]};
            cy = {frame_bytes[base + 2], frame_bytes[base + 3][3:0]};
            if (live_cfg.mirror_x_en && live_cfg.axis_x_max != 12'd0)
                cx = mirror_coord(cx, live_cfg.axis_x_max);
            if (live_cfg.mirror_y_en && live_cfg.axis_y_max != 12'd0)
                cy = mirror_coord(cy, live_cfg.axis_y_max);
            if (live_cfg.swap_axes_en)
            begin
                tmp = cx;
                cx = cy;
                cy = tmp;
            end
            xs[kept] = cx;
            ys[kept] = cy;
            kept++;
        end
        bt.frame_status = ST_VALID;
        if (kept == 0)
        begin
            decoded_beats.push_back(bt);
            return;
        end
        for (i = 0; i < kept; i++)
        begin
            bt.point_valid   = 1'b1;
            bt.point_x       = xs[i];
            bt.point_y       = ys[i];
            bt.point_total   = CNT_W'(kept);
            bt.last_of_frame = (i == kept - 1);
            decoded_beats.push_back(bt);
        end
    endtask

    // One accepted report byte into the frame store
    task automatic absorb_report_byte(input logic [7:0] b);
        frame_bytes[fill_pos] = b;
        if (b != 8'd0)
            saw_nonzero = 1'b1;
        if (fill_pos + 1 < FRAME_BYTES)
            fill_pos++;
        else
        begin
            decode_stored_frame();
            fill_pos = 0;
            saw_nonzero = 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: register writes, accepted bytes, result beats, watchdog
    always @(posedge clk)
    begin : monitor
        beat_t want;
        bit    moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_reg_t'(cfg_index))
                    REG_AXIS_X_MAX:    live_cfg.axis_x_max    = cfg_data;
                    REG_AXIS_Y_MAX:    live_cfg.axis_y_max    = cfg_data;
                    REG_MIRROR_X_EN:   live_cfg.mirror_x_en   = cfg_data[0];
                    REG_MIRROR_Y_EN:   live_cfg.mirror_y_en   = cfg_data[0];
                    REG_SWAP_AXES_EN:  live_cfg.swap_axes_en  = cfg_data[0];
                    REG_POINTS_WANTED: live_cfg.points_wanted = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                absorb_report_byte(report_byte);
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (decoded_beats.size() == 0)
                begin
                    $error("result beat with nothing pending: status %0d x %0d y %0d",
                           frame_status, point_x, point_y);
                    fail_count++;
                end
                else
                begin
                    want = decoded_beats.pop_front();
                    check_field("frame_status", want.frame_status, frame_status);
                    check_field("ack_needed", want.ack_needed, ack_needed);
                    check_field("point_valid", want.point_valid, point_valid);
                    check_field("point_x", want.point_x, point_x);
                    check_field("point_y", want.point_y, point_y);
                    check_field("point_total", want.point_total, point_total);
                    check_field("last_of_frame", want.last_of_frame, last_of_frame);
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random stalls, a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 17);
    end

    // Offer one byte; valid stays up unless a gap follows
    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        report_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        if (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic send_frame(input frame_t f);
        int i;
        for (i = 0; i < FRAME_BYTES; i++)
            send_byte(f[i]);
    endtask

    // Stop offering, wait out every pending beat and the pipeline tail
    task automatic drain();
        in_valid <= 1'b0;
        while (decoded_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all six registers back to back; junk fills unused data bits
    task automatic write_cfg(input cfg_t c, input bit junk);
        cfg_reg_t    order [6];
        logic [11:0] val;
        logic [11:0] noise;
        int          i;
        order = '{REG_AXIS_X_MAX, REG_AXIS_Y_MAX, REG_MIRROR_X_EN, REG_MIRROR_Y_EN,
                  REG_SWAP_AXES_EN, REG_POINTS_WANTED};
        for (i = 0; i < 6; i++)
        begin
            noise = junk ? 12'($urandom_range(4095)) : 12'd0;
            case (order[i])
                REG_AXIS_X_MAX:    val = c.axis_x_max;
                REG_AXIS_Y_MAX:    val = c.axis_y_max;
                REG_MIRROR_X_EN:   val = {noise[11:1], c.mirror_x_en};
                REG_MIRROR_Y_EN:   val = {noise[11:1], c.mirror_y_en};
                REG_SWAP_AXES_EN:  val = {noise[11:1], c.swap_axes_en};
                REG_POINTS_WANTED: val = {noise[11:2], c.points_wanted};
                default:           val = 12'd0;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= val;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t make_cfg(input logic [11:0] xm, input logic [11:0] ym,
                                      input bit mx, input bit my, input bit sw,
                                      input logic [1:0] pw);
        cfg_t c;
        c.axis_x_max    = xm;
        c.axis_y_max    = ym;
        c.mirror_x_en   = mx;
        c.mirror_y_en   = my;
        c.swap_axes_en  = sw;
        c.points_wanted = pw;
        return c;
    endfunction

    function automatic logic [11:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 12'd0;
        if (r < 30)
            return 12'hFFF;
        return 12'($urandom_range(4095));
    endfunction

    function automatic logic [3:0] rand_event();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return EV_IDLE;
        if (r < 30)
            return EV_SKIP;
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [7:0] rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'd0;
        if (r < 35)
            return {1'($urandom_range(1)), 7'd1};
        if (r < 80)
            return {1'($urandom_range(1)), 7'd2};
        return 8'($urandom_range(255));
    endfunction

    function automatic cfg_t random_cfg();
        return make_cfg(rand_coord(), rand_coord(), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        2'($urandom_range(3)));
    endfunction

    // Well-formed frame around two points, filler bytes random
    function automatic frame_t valid_frame(input logic [7:0] count_byte,
                                           input logic [3:0] ev0, input logic [3:0] ev1,
                                           input logic [11:0] x0, input logic [11:0] y0,
                                           input logic [11:0] x1, input logic [11:0] y1);
        frame_t f;
        int     i;
        for (i = 0; i < FRAME_BYTES; i++)
            f[i] = 8'($urandom_range(255));
        f[0] = {4'($urandom_range(15)), ev0};
        while (f[0] == HDR_EMPTY || f[0] == ACK_CODE)
            f[0][7:4] = 4'($urandom_range(15));
        f[1] = x0[11:4];
        f[2] = y0[11:4];
        f[3] = {x0[3:0], y0[3:0]};
        f[BYTE_LID][LID_BIT] = 1'b0;
        f[BYTE_COUNT] = count_byte;
        f[BYTE_ACK] = ACK_CODE;
        f[7] = {4'($urandom_range(15)), ev1};
        f[8] = x1[11:4];
        f[9] = y1[11:4];
        f[10] = {x1[3:0], y1[3:0]};
        return f;
    endfunction

    function automatic frame_t make_frame(input frame_kind_t kind);
        frame_t f;
        int     i;
        if (kind == FK_IDLE)
            return '0;
        if (kind == FK_NOISE)
        begin
            for (i = 0; i < FRAME_BYTES; i++)
                f[i] = 8'($urandom_range(255));
            return f;
        end
        f = valid_frame(rand_count(), rand_event(), rand_event(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord());
        case (kind)
            FK_HDR_ZERO: f[0] = HDR_EMPTY;
            FK_HDR_ACK:  f[0] = ACK_CODE;
            FK_BAD_ACK:
            begin
                do
                    f[BYTE_ACK] = 8'($urandom_range(255));
                while (f[BYTE_ACK] == ACK_CODE);
            end
            FK_LID:      f[BYTE_LID][LID_BIT] = 1'b1;
            default: ;
        endcase
        return f;
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return FK_VALID;
        if (r < 76)
            return FK_IDLE;
        if (r < 82)
            return FK_NOISE;
        if (r < 87)
            return FK_HDR_ZERO;
        if (r < 91)
            return FK_HDR_ACK;
        if (r < 96)
            return FK_BAD_ACK;
        return FK_LID;
    endfunction

    // Reset configuration: idle, drop reasons, count clamp, skipped events
    task automatic test_default_config();
        frame_t f;
        send_frame('0);
        send_frame(valid_frame(8'd2, 4'h1, 4'hF, 12'h000, 12'hFFF, 12'hFFF, 12'h000));
        // count field far above capacity with its top bit set
        send_frame(valid_frame(8'hFF, 4'h2, 4'h3, 12'h123, 12'h456, 12'h789, 12'hABC));
        send_frame(valid_frame(8'h00, 4'h1, 4'h1, 12'h010, 12'h020, 12'h030, 12'h040));
        send_frame(valid_frame(8'd2, EV_IDLE, EV_SKIP, 12'h111, 12'h222, 12'h333, 12'h444));
        send_frame(valid_frame(8'd2, EV_SKIP, 4'h9, 12'h555, 12'h666, 12'h777, 12'h888));
        send_frame(valid_frame(8'd1, 4'h4, 4'h4, 12'h999, 12'hAAA, 12'hBBB, 12'hCCC));
        send_frame(make_frame(FK_HDR_ZERO));
        send_frame(make_frame(FK_HDR_ACK));
        send_frame(make_frame(FK_BAD_ACK));
        send_frame(make_frame(FK_LID));
        // only the final byte nonzero: header is empty, frame dropped
        f = '0;
        f[FRAME_BYTES-1] = 8'h01;
        send_frame(f);
        drain();
    endtask

    // Mirror at, below and above the maximum; swap; points wanted 0..3
    task automatic test_mirror_and_swap();
        write_cfg(make_cfg(12'hFFF, 12'd1000, 1'b1, 1'b1, 1'b0, 2'd2), 1'b0);
        send_frame(valid_frame(8'd2, 4'h1, 4'h2, 12'd0, 12'd1000, 12'hFFF, 12'd1500));
        send_frame(valid_frame(8'd2, 4'h1, 4'h2, 12'd1, 12'd999, 12'hFFE, 12'd0));
        drain();
        // zero maxima leave coordinates alone; zero wanted keeps one point
        write_cfg(make_cfg(12'd0, 12'd0, 1'b1, 1'b1, 1'b1, 2'd0), 1'b1);
        send_frame(valid_frame(8'd2, 4'h1, 4'h2, 12'h123, 12'hFED, 12'h456, 12'hCBA));
        drain();
        write_cfg(make_cfg(12'd2048, 12'hFFF, 1'b0, 1'b1, 1'b1, 2'd3), 1'b1);
        send_frame(valid_frame(8'd2, 4'h1, 4'h2, 12'd3000, 12'd0, 12'd100, 12'hFFF));
        drain();
        write_cfg(make_cfg(12'd2048, 12'd2048, 1'b1, 1'b0, 1'b0, 2'd1), 1'b0);
        send_frame(valid_frame(8'd2, 4'h1, 4'h2, 12'd2047, 12'd2049, 12'd5, 12'd6));
        drain();
    endtask

    // Receiver holds off while frames keep coming, so the input stalls
    task automatic test_backpressure();
        int i;
        write_cfg(random_cfg(), 1'b0);
        no_idle = 1'b1;
        hold_req = 1'b1;
        for (i = 0; i < 8; i++)
            send_frame(make_frame(FK_VALID));
        no_idle = 1'b0;
        drain();
    endtask

    // Mostly well-formed frames, some broken or noise; new settings per phase
    task automatic test_random_stream();
        int frames;
        int sent;
        frames = 0;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (frames % 12 == 0)
            begin
                drain();
                write_cfg(random_cfg(), 1'($urandom_range(1)));
            end
            no_idle = (frames >= 40 && frames < 56);
            send_frame(make_frame(pick_kind()));
            sent += FRAME_BYTES;
            frames++;
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_mirror_and_swap();
        test_backpressure();
        test_random_stream();
        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== touch_report_frame_decoder.f =====
hw/rtl/trfd_pkg.sv
hw/rtl/trfd_cfg_regs.sv
hw/rtl/trfd_front.sv
hw/rtl/trfd_job_fifo.sv
hw/rtl/trfd_back.sv
hw/rtl/touch_report_frame_decoder.sv
tb/tb_touch_report_frame_decoder.sv
